// ===== hw/rtl/rtwc_pkg.sv =====
// Package for the routing-track window counter.
// Holds the widths, the register map and the controller/datapath command types.
// No dependencies.
package rtwc_pkg;

  localparam int COORD_BITS   = 32;
  localparam int COUNT_BITS   = 16;
  localparam int PITCH_BITS   = 24;
  localparam int SUM_BITS     = 32;
  localparam int CFG_IDX_BITS = 3;

  // (track_total - 1) * pitch
  localparam int PROD_BITS = COUNT_BITS + PITCH_BITS;
  // Signed width that holds coordinates, the last track position and their differences.
  localparam int POS_BITS  = ((COORD_BITS > PROD_BITS) ? COORD_BITS : PROD_BITS) + 2;
  // Dividend width of the divider: an offset plus pitch - 1.
  localparam int DIV_BITS  = PROD_BITS + 1;
  // One quotient bit per divider step.
  localparam int STEP_BITS = $clog2(COUNT_BITS);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_COUNT_VERTICAL = CFG_IDX_BITS'(0),
    REG_WINDOW_X_MIN   = CFG_IDX_BITS'(1),
    REG_WINDOW_X_MAX   = CFG_IDX_BITS'(2),
    REG_WINDOW_Y_MIN   = CFG_IDX_BITS'(3),
    REG_WINDOW_Y_MAX   = CFG_IDX_BITS'(4)
  } cfg_reg_e;

  typedef struct packed {
    logic accept;       // latch the request and the selected span
    logic mul;          // (n - 1) * pitch
    logic span_last;    // last track position and high - 1
    logic span_clip;    // empty test and clipped span ends
    logic span_offset;  // offsets of the clipped ends from the first track
    logic load_first;   // start the ceiling division
    logic load_last;    // keep the first index, start the floor division
    logic div_step;     // one quotient bit
    logic finish;       // form the result and update the total
  } rtwc_cmd_t;

  typedef struct packed {
    logic span_empty;   // group counts zero, divisions can be skipped
  } rtwc_status_t;

endpackage

// ===== hw/rtl/rtwc_in_if.sv =====
// Input channel carrying one track-group descriptor per request.
// Depends on rtwc_pkg.
interface rtwc_in_if
  import rtwc_pkg::*;
();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] first_position;
  logic [COUNT_BITS-1:0]        track_total;
  logic [PITCH_BITS-1:0]        pitch;
  logic                         runs_horizontal;
  logic                         last_group;

  modport source (output valid, first_position, track_total, pitch, runs_horizontal,
                  last_group, input ready);
  modport sink   (input valid, first_position, track_total, pitch, runs_horizontal,
                  last_group, output ready);
endinterface

// ===== hw/rtl/rtwc_out_if.sv =====
// Output channel carrying one count result per request.
// Depends on rtwc_pkg.
interface rtwc_out_if
  import rtwc_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [COUNT_BITS-1:0] group_hits;
  logic [SUM_BITS-1:0]   running_hits;
  logic                  pitch_error;
  logic                  query_done;

  modport source (output valid, group_hits, running_hits, pitch_error, query_done,
                  input ready);
  modport sink   (input valid, group_hits, running_hits, pitch_error, query_done,
                  output ready);
endinterface

// ===== hw/rtl/rtwc_cfg_if.sv =====
// Configuration write channel: register index and write data.
// Depends on rtwc_pkg.
interface rtwc_cfg_if
  import rtwc_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [CFG_IDX_BITS-1:0] index;
  logic [COORD_BITS-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/rtwc_ctrl.sv =====
// Controller of the routing-track window counter: sequences the datapath.
// Depends on rtwc_pkg.
module rtwc_ctrl
  import rtwc_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output rtwc_cmd_t    cmd_o,
  input  rtwc_status_t status_i
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_LAST,
    ST_CLIP,
    ST_OFFSET,
    ST_LOAD_A,
    ST_DIV_A,
    ST_LOAD_B,
    ST_DIV_B,
    ST_FINISH
  } state_e;

  state_e               state_q, state_d;
  logic [STEP_BITS-1:0] step_q, step_d;
  logic                 out_valid_q, out_valid_d;
  logic                 step_last;
  logic                 slot_free;

  assign step_last = (step_q == STEP_BITS'(COUNT_BITS - 1));
  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_LAST;
      end
      ST_LAST: begin
        cmd_o.span_last = 1'b1;
        state_d         = ST_CLIP;
      end
      ST_CLIP: begin
        cmd_o.span_clip = 1'b1;
        state_d         = ST_OFFSET;
      end
      ST_OFFSET: begin
        cmd_o.span_offset = 1'b1;
        state_d           = status_i.span_empty ? ST_FINISH : ST_LOAD_A;
      end
      ST_LOAD_A: begin
        cmd_o.load_first = 1'b1;
        step_d           = '0;
        state_d          = ST_DIV_A;
      end
      ST_DIV_A: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + STEP_BITS'(1);
        if (step_last) begin
          state_d = ST_LOAD_B;
        end
      end
      ST_LOAD_B: begin
        cmd_o.load_last = 1'b1;
        step_d          = '0;
        state_d         = ST_DIV_B;
      end
      ST_DIV_B: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + STEP_BITS'(1);
        if (step_last) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // The result register is written only once the previous result has left.
        if (slot_free) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== hw/rtl/rtwc_datapath.sv =====
// Datapath of the routing-track window counter: window registers, span arithmetic,
// a shared shift-subtract divider and the saturating total. Depends on rtwc_pkg.
module rtwc_datapath
  import rtwc_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_write_i,
  input  logic [CFG_IDX_BITS-1:0]      cfg_index_i,
  input  logic [COORD_BITS-1:0]        cfg_data_i,
  input  logic signed [COORD_BITS-1:0] first_position_i,
  input  logic [COUNT_BITS-1:0]        track_total_i,
  input  logic [PITCH_BITS-1:0]        pitch_i,
  input  logic                         runs_horizontal_i,
  input  logic                         last_group_i,
  input  rtwc_cmd_t                    cmd_i,
  output rtwc_status_t                 status_o,
  output logic [COUNT_BITS-1:0]        group_hits_o,
  output logic [SUM_BITS-1:0]          running_hits_o,
  output logic                         pitch_error_o,
  output logic                         query_done_o
);

  // Configuration registers
  logic                         count_vertical_q;
  logic signed [COORD_BITS-1:0] window_x_min_q, window_x_max_q;
  logic signed [COORD_BITS-1:0] window_y_min_q, window_y_max_q;

  // Latched request
  logic signed [COORD_BITS-1:0] s_q, lo_q, hi_q;
  logic [COUNT_BITS-1:0]        n_q;
  logic [PITCH_BITS-1:0]        p_q;
  logic                         selected_q;
  logic                         last_q;

  // Span arithmetic
  logic [PROD_BITS-1:0]       prod_q;
  logic signed [POS_BITS-1:0] last_pos_q, hi_m1_q, from_q, to_q;
  logic                       empty_q;
  logic [PROD_BITS-1:0]       a_q, b_q;
  logic signed [POS_BITS-1:0] s_ext, lo_ext, hi_ext;
  logic [COUNT_BITS-1:0]      n_m1;

  // Divider
  logic [DIV_BITS-1:0]   rem_q, dvs_q;
  logic [COUNT_BITS-1:0] quo_q, first_idx_q;
  logic                  rem_ge;

  // Result
  logic [SUM_BITS-1:0]   acc_q;
  logic [COUNT_BITS-1:0] hits;
  logic [SUM_BITS:0]     sum_wide;
  logic [SUM_BITS-1:0]   sum_sat;
  logic [COUNT_BITS-1:0] group_hits_q;
  logic [SUM_BITS-1:0]   running_hits_q;
  logic                  pitch_error_q, query_done_q;

  assign s_ext  = POS_BITS'(s_q);
  assign lo_ext = POS_BITS'(lo_q);
  assign hi_ext = POS_BITS'(hi_q);
  assign n_m1   = n_q - COUNT_BITS'(1);
  assign rem_ge = (rem_q >= dvs_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_vertical_q <= 1'b0;
      window_x_min_q   <= '0;
      window_x_max_q   <= '0;
      window_y_min_q   <= '0;
      window_y_max_q   <= '0;
    end else if (cfg_write_i) begin
      unique case (cfg_index_i)
        REG_COUNT_VERTICAL: count_vertical_q <= cfg_data_i[0];
        REG_WINDOW_X_MIN:   window_x_min_q   <= $signed(cfg_data_i);
        REG_WINDOW_X_MAX:   window_x_max_q   <= $signed(cfg_data_i);
        REG_WINDOW_Y_MIN:   window_y_min_q   <= $signed(cfg_data_i);
        REG_WINDOW_Y_MAX:   window_y_max_q   <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      s_q        <= first_position_i;
      n_q        <= track_total_i;
      p_q        <= pitch_i;
      last_q     <= last_group_i;
      // Horizontal tracks are counted against y, vertical ones against x.
      selected_q <= (runs_horizontal_i != count_vertical_q);
      lo_q       <= count_vertical_q ? window_x_min_q : window_y_min_q;
      hi_q       <= count_vertical_q ? window_x_max_q : window_y_max_q;
    end
    if (cmd_i.mul) begin
      prod_q <= PROD_BITS'(n_m1) * PROD_BITS'(p_q);
    end
    if (cmd_i.span_last) begin
      last_pos_q <= s_ext + $signed(POS_BITS'(prod_q));
      hi_m1_q    <= hi_ext - POS_BITS'(1);
    end
    if (cmd_i.span_clip) begin
      empty_q <= !selected_q || (n_q == '0) || (p_q == '0) ||
                 (s_ext >= hi_ext) || (last_pos_q < lo_ext);
      from_q  <= (lo_ext > s_ext) ? lo_ext : s_ext;
      to_q    <= (last_pos_q < hi_m1_q) ? last_pos_q : hi_m1_q;
    end
    if (cmd_i.span_offset) begin
      a_q <= PROD_BITS'(from_q - s_ext);
      b_q <= PROD_BITS'(to_q - s_ext);
    end
    // Both quotients are below 2**COUNT_BITS, so the divisor starts shifted
    // up by COUNT_BITS - 1 and one quotient bit is produced per step.
    if (cmd_i.load_first) begin
      rem_q <= DIV_BITS'(a_q) + DIV_BITS'(p_q) - DIV_BITS'(1);
      dvs_q <= DIV_BITS'(p_q) << (COUNT_BITS - 1);
    end else if (cmd_i.load_last) begin
      first_idx_q <= quo_q;
      rem_q       <= DIV_BITS'(b_q);
      dvs_q       <= DIV_BITS'(p_q) << (COUNT_BITS - 1);
    end else if (cmd_i.div_step) begin
      if (rem_ge) begin
        rem_q <= rem_q - dvs_q;
      end
      quo_q <= {quo_q[COUNT_BITS-2:0], rem_ge};
      dvs_q <= dvs_q >> 1;
    end
    if (cmd_i.finish) begin
      group_hits_q   <= hits;
      running_hits_q <= sum_sat;
      pitch_error_q  <= (p_q == '0);
      query_done_q   <= last_q;
    end
  end

  always_comb begin
    if (empty_q || (quo_q < first_idx_q)) begin
      hits = '0;
    end else begin
      hits = quo_q - first_idx_q + COUNT_BITS'(1);
    end
    sum_wide = {1'b0, acc_q} + (SUM_BITS + 1)'(hits);
    sum_sat  = sum_wide[SUM_BITS] ? {SUM_BITS{1'b1}} : sum_wide[SUM_BITS-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (cmd_i.finish) begin
      acc_q <= last_q ? '0 : sum_sat;
    end
  end

  assign status_o.span_empty = empty_q;
  assign group_hits_o        = group_hits_q;
  assign running_hits_o      = running_hits_q;
  assign pitch_error_o       = pitch_error_q;
  assign query_done_o        = query_done_q;

endmodule

// ===== hw/rtl/routing_track_window_counter_top.sv =====
// Routing-track window counter. Each request is one track group; for the
// configured window and direction the block returns the number of the group's
// tracks inside the half-open span and a saturating running total that clears
// after the group marked last. When a group reaches the span, its result is
// written to the output register after two 16-step passes of the single
// shift-subtract divider (ceiling of the first index, floor of the last). A
// group that is empty, has zero pitch, runs in the other direction or lies
// outside the span skips both passes. A result is not written while the
// previous one is still held in the output register. The next request is
// taken in the cycle after a result is written. A new request is taken while
// the previous result still waits in the output register. Configuration
// writes are always accepted and take effect at once.
// Depends on rtwc_pkg, the channel interfaces, rtwc_ctrl and rtwc_datapath.
module routing_track_window_counter_top
  import rtwc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  rtwc_cfg_if.sink   cfg_i,
  rtwc_in_if.sink    in_i,
  rtwc_out_if.source out_o
);

  rtwc_cmd_t    cmd;
  rtwc_status_t status;

  assign cfg_i.ready = 1'b1;

  rtwc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  rtwc_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_write_i       (cfg_i.valid),
    .cfg_index_i       (cfg_i.index),
    .cfg_data_i        (cfg_i.data),
    .first_position_i  (in_i.first_position),
    .track_total_i     (in_i.track_total),
    .pitch_i           (in_i.pitch),
    .runs_horizontal_i (in_i.runs_horizontal),
    .last_group_i      (in_i.last_group),
    .cmd_i             (cmd),
    .status_o          (status),
    .group_hits_o      (out_o.group_hits),
    .running_hits_o    (out_o.running_hits),
    .pitch_error_o     (out_o.pitch_error),
    .query_done_o      (out_o.query_done)
  );

endmodule

// ===== hw/rtl/rtwc_checker.sv =====
// Port-level checker for the routing-track window counter and its bind.
// Depends on rtwc_pkg and routing_track_window_counter_top.
module rtwc_checker
  import rtwc_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  out_valid_i,
  input logic                  out_ready_i,
  input logic [COUNT_BITS-1:0] group_hits_i,
  input logic [SUM_BITS-1:0]   running_hits_i,
  input logic                  pitch_error_i,
  input logic                  query_done_i
);

  logic query_start_q;

  // Set while the next result is the first one of a query.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      query_start_q <= 1'b1;
    end else if (out_valid_i && out_ready_i) begin
      query_start_q <= query_done_i;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(running_hits_i) &&
                                   $stable(group_hits_i))
    else $error("result changed or dropped while stalled");

  a_pitch_error_no_hits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && pitch_error_i |-> group_hits_i == '0)
    else $error("zero pitch group reported hits");

  a_total_covers_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> running_hits_i >= SUM_BITS'(group_hits_i))
    else $error("running total below the group count");

  a_query_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && query_start_q |-> running_hits_i == SUM_BITS'(group_hits_i))
    else $error("running total not cleared at the start of a query");

endmodule

bind routing_track_window_counter_top rtwc_checker u_rtwc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .group_hits_i   (out_o.group_hits),
  .running_hits_i (out_o.running_hits),
  .pitch_error_i  (out_o.pitch_error),
  .query_done_i   (out_o.query_done)
);

// ===== bench/routing_track_window_counter_top_tb.sv =====
// Testbench for routing_track_window_counter_top: track-group requests go through a
// queue-fed driver, results are checked against an in-bench count of tracks in the window.
// Depends on rtwc_pkg, the rtwc channel interfaces and the counter RTL.
module routing_track_window_counter_top_tb;
  import rtwc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int     CLK_PERIOD     = 10;
  localparam int     DRAIN_CYCLES   = 50;
  localparam int     HOLD_CYCLES    = 400;
  localparam int     WATCHDOG_LIMIT = 5000;
  localparam int     MAX_REPORTS    = 40;
  localparam int     RANDOM_PHASES  = 12;
  localparam int     PHASE_GROUPS   = 82;
  localparam int     PRESSURE_PHASE = 6;
  localparam longint COORD_MAX      = (longint'(1) <<< (COORD_BITS - 1)) - 1;
  localparam longint COORD_MIN      = -COORD_MAX - 1;
  localparam longint PITCH_MAX      = (longint'(1) <<< PITCH_BITS) - 1;
  localparam longint TRACKS_MAX     = (longint'(1) <<< COUNT_BITS) - 1;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] first_position;
    logic [COUNT_BITS-1:0]        track_total;
    logic [PITCH_BITS-1:0]        pitch;
    logic                         runs_horizontal;
    logic                         last_group;
  } group_desc_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0] group_hits;
    logic [SUM_BITS-1:0]   running_hits;
    logic                  pitch_error;
    logic                  query_done;
  } track_count_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  rtwc_cfg_if cfg_if ();
  rtwc_in_if  in_if ();
  rtwc_out_if out_if ();

  routing_track_window_counter_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  group_desc_t  pending_groups[$];
  track_count_t expected_counts[$];

  // Window registers as the block should hold them, and the query total.
  logic                         win_count_vertical = 1'b0;
  logic signed [COORD_BITS-1:0] win_x_min = '0;
  logic signed [COORD_BITS-1:0] win_x_max = '0;
  logic signed [COORD_BITS-1:0] win_y_min = '0;
  logic signed [COORD_BITS-1:0] win_y_max = '0;
  logic [SUM_BITS-1:0]          query_total = '0;

  // Span the stimulus aims at, kept by the stimulus process.
  logic   aim_vertical;
  longint aim_lo;
  longint aim_hi;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_requests  = 0;
  int hold_seen      = 0;
  int hold_left      = 0;
  int stall_cycles   = 0;
  int fail_count     = 0;
  int groups_taken   = 0;
  int counts_checked = 0;
  int zero_pitch     = 0;
  int queries_closed = 0;
  int window_setups  = 0;

  function automatic longint to_coord(longint v);
    if (v > COORD_MAX) return COORD_MAX;
    if (v < COORD_MIN) return COORD_MIN;
    return v;
  endfunction

  // Tracks at first + k*pitch, k < total, that fall in [lo, hi).
  function automatic longint tracks_in_span(longint first, longint total, longint pitch,
                                            longint lo, longint hi);
    longint last_pos, from_pos, to_pos, first_idx, last_idx;
    if (total == 0 || pitch == 0) return 0;
    last_pos = first + (total - 1) * pitch;
    if (first >= hi || last_pos < lo) return 0;
    from_pos = (lo > first) ? lo : first;
    to_pos   = (last_pos < hi - 1) ? last_pos : hi - 1;
    if (to_pos < first) return 0;
    first_idx = (from_pos - first + pitch - 1) / pitch;
    last_idx  = (to_pos - first) / pitch;
    return (last_idx >= first_idx) ? last_idx - first_idx + 1 : 0;
  endfunction

  task automatic report_field(string field, longint want, longint got);
    if (want != got) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
    end
  endtask

  // Request driver.
  always @(posedge clk_i) begin : group_driver
    group_desc_t next_group;
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_if.ready) begin
      if (pending_groups.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_group = pending_groups.pop_front();
        in_if.valid           <= 1'b1;
        in_if.first_position  <= next_group.first_position;
        in_if.track_total     <= next_group.track_total;
        in_if.pitch           <= next_group.pitch;
        in_if.runs_horizontal <= next_group.runs_horizontal;
        in_if.last_group      <= next_group.last_group;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Result receiver with random stalls and an occasional long hold-off.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else if (hold_seen != hold_requests) begin
      hold_seen    <= hold_requests;
      hold_left    <= HOLD_CYCLES;
      out_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: tracks register writes, predicts each accepted group and checks results.
  always @(posedge clk_i) begin : count_monitor
    track_count_t     want;
    longint           lo, hi, hits;
    logic [SUM_BITS:0] total;
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          REG_COUNT_VERTICAL: win_count_vertical = cfg_if.data[0];
          REG_WINDOW_X_MIN:   win_x_min = $signed(cfg_if.data);
          REG_WINDOW_X_MAX:   win_x_max = $signed(cfg_if.data);
          REG_WINDOW_Y_MIN:   win_y_min = $signed(cfg_if.data);
          REG_WINDOW_Y_MAX:   win_y_max = $signed(cfg_if.data);
          default: ;
        endcase
      end
      if (in_if.valid && in_if.ready) begin
        hits = 0;
        if (in_if.runs_horizontal != win_count_vertical) begin
          lo   = win_count_vertical ? win_x_min : win_y_min;
          hi   = win_count_vertical ? win_x_max : win_y_max;
          hits = tracks_in_span(in_if.first_position, in_if.track_total, in_if.pitch, lo, hi);
        end
        want.group_hits = hits[COUNT_BITS-1:0];
        total = {1'b0, query_total} + want.group_hits;
        want.running_hits = total[SUM_BITS] ? '1 : total[SUM_BITS-1:0];
        want.pitch_error  = (in_if.pitch == '0);
        want.query_done   = in_if.last_group;
        // The total restarts once the last group of a query has been counted.
        query_total = in_if.last_group ? '0 : want.running_hits;
        expected_counts.insert(expected_counts.size(), want);
        groups_taken++;
      end
      if (out_if.valid && out_if.ready) begin
        if (expected_counts.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result, expected none, actual hits %0d total %0d",
                   $time, out_if.group_hits, out_if.running_hits);
        end else begin
          want = expected_counts.pop_front();
          report_field("group_hits", want.group_hits, out_if.group_hits);
          report_field("running_hits", want.running_hits, out_if.running_hits);
          report_field("pitch_error", want.pitch_error, out_if.pitch_error);
          report_field("query_done", want.query_done, out_if.query_done);
          counts_checked++;
          if (want.pitch_error) zero_pitch++;
          if (want.query_done) queries_closed++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no request moved for %0d cycles", $time, stall_cycles);
      $display("routing_track_window_counter_top test failed");
      $finish;
    end
  end

  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_groups.size() != 0 || in_if.valid || expected_counts.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [COORD_BITS-1:0] value);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk_i);
    while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic program_window(logic vertical, longint x_lo, longint x_hi,
                                longint y_lo, longint y_hi);
    wait_idle();
    write_reg(REG_COUNT_VERTICAL, COORD_BITS'(vertical));
    write_reg(REG_WINDOW_X_MIN, COORD_BITS'(x_lo));
    write_reg(REG_WINDOW_X_MAX, COORD_BITS'(x_hi));
    write_reg(REG_WINDOW_Y_MIN, COORD_BITS'(y_lo));
    write_reg(REG_WINDOW_Y_MAX, COORD_BITS'(y_hi));
    @(negedge clk_i);
    aim_vertical = vertical;
    aim_lo       = vertical ? x_lo : y_lo;
    aim_hi       = vertical ? x_hi : y_hi;
    window_setups++;
  endtask

  task automatic queue_group(longint first, longint total, longint pitch,
                             logic horizontal, logic last);
    group_desc_t desc;
    desc.first_position  = COORD_BITS'(to_coord(first));
    desc.track_total     = COUNT_BITS'(total);
    desc.pitch           = PITCH_BITS'(pitch);
    desc.runs_horizontal = horizontal;
    desc.last_group      = last;
    pending_groups.insert(pending_groups.size(), desc);
  endtask

  function automatic void random_span(output longint lo, output longint hi);
    int     pick;
    longint width;
    lo   = $urandom_range(1) ? longint'($signed($urandom)) : longint'($urandom_range(2000)) - 1000;
    pick = $urandom_range(99);
    if (pick < 60)      width = $urandom_range(5000);
    else if (pick < 75) width = $urandom;
    else if (pick < 85) width = 0;
    else                width = -longint'($urandom_range(1000, 1));
    hi = to_coord(lo + width);
  endfunction

  // Most groups straddle an edge of the aimed span so that the counts are partial.
  task automatic queue_random_group();
    int     pick;
    longint pitch, total, first, k, width;
    logic   horizontal;
    pick = $urandom_range(99);
    if (pick < 8)       pitch = 0;
    else if (pick < 50) pitch = $urandom_range(64, 1);
    else if (pick < 80) pitch = $urandom_range(4096, 1);
    else                pitch = $urandom_range(32'(PITCH_MAX), 0);
    pick = $urandom_range(99);
    if (pick < 5)       total = 0;
    else if (pick < 70) total = $urandom_range(300, 1);
    else if (pick < 90) total = $urandom_range(32'(TRACKS_MAX), 0);
    else                total = TRACKS_MAX;
    k     = (total == 0) ? 0 : $urandom_range(32'(total - 1));
    width = (aim_hi > aim_lo) ? aim_hi - aim_lo : 0;
    pick  = $urandom_range(99);
    if (pick < 15)      first = longint'($signed($urandom));
    else if (pick < 45) first = aim_lo - k * pitch + longint'($urandom_range(4)) - 2;
    else if (pick < 75) first = aim_hi - k * pitch + longint'($urandom_range(4)) - 2;
    else                first = aim_lo + longint'($urandom_range(32'(width)));
    horizontal = ($urandom_range(99) < 80) ? !aim_vertical : aim_vertical;
    queue_group(first, total, pitch, horizontal, $urandom_range(5) == 0);
  endtask

  initial begin : stimulus
    longint x_lo, x_hi, y_lo, y_hi;
    int     idx;
    in_if.valid           = 1'b0;
    in_if.first_position  = '0;
    in_if.track_total     = '0;
    in_if.pitch           = '0;
    in_if.runs_horizontal = 1'b0;
    in_if.last_group      = 1'b0;
    cfg_if.valid          = 1'b0;
    cfg_if.index          = REG_COUNT_VERTICAL;
    cfg_if.data           = '0;
    out_if.ready          = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // Horizontal tracks against y in [0, 100).
    program_window(1'b0, 0, 0, 0, 100);
    queue_group(0, 10, 10, 1'b1, 1'b0);
    queue_group(-5, 20, 10, 1'b1, 1'b0);
    queue_group(0, 10, 10, 1'b0, 1'b0);
    queue_group(0, 0, 10, 1'b1, 1'b0);
    queue_group(0, 10, 0, 1'b1, 1'b0);
    queue_group(0, 10, 0, 1'b0, 1'b0);
    queue_group(100, 10, 1, 1'b1, 1'b0);
    queue_group(-1000, 5, 10, 1'b1, 1'b0);
    queue_group(99, 1, 1, 1'b1, 1'b0);
    queue_group(-100, 5, 100, 1'b1, 1'b0);
    queue_group(5, 3, 50, 1'b1, 1'b0);
    queue_group(COORD_MAX, TRACKS_MAX, PITCH_MAX, 1'b1, 1'b0);
    queue_group(COORD_MIN, TRACKS_MAX, PITCH_MAX, 1'b1, 1'b1);
    wait_idle();
    // Writes to unmapped indexes must leave the window alone.
    for (idx = int'(REG_WINDOW_Y_MAX) + 1; idx < (1 << CFG_IDX_BITS); idx++) begin
      write_reg(CFG_IDX_BITS'(idx), '1);
    end
    @(negedge clk_i);
    queue_group(0, 1, 1, 1'b1, 1'b1);

    // Vertical tracks against the widest x span.
    program_window(1'b1, COORD_MIN, COORD_MAX, 0, 0);
    queue_group(COORD_MIN, TRACKS_MAX, 1, 1'b0, 1'b0);
    queue_group(COORD_MAX - 1, TRACKS_MAX, PITCH_MAX, 1'b0, 1'b0);
    queue_group(COORD_MAX, 1, 1, 1'b0, 1'b0);
    queue_group(0, 10, 1, 1'b1, 1'b1);
    // Inverted and empty spans.
    program_window(1'b1, 100, 0, 0, 0);
    queue_group(0, 200, 1, 1'b0, 1'b1);
    program_window(1'b0, 0, 0, 50, 50);
    queue_group(0, 100, 1, 1'b1, 1'b0);
    // A span that fits between two neighboring tracks, then one that is full.
    program_window(1'b0, 0, 0, 10, 90);
    queue_group(0, 5, 100, 1'b1, 1'b1);
    queue_group(10, 80, 1, 1'b1, 1'b1);

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: program_window(1'b1, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN);
        1: program_window(1'b0, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX);
        2: program_window($urandom_range(1), COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN);
        default: begin
          random_span(x_lo, x_hi);
          random_span(y_lo, y_hi);
          program_window($urandom_range(1), x_lo, x_hi, y_lo, y_hi);
        end
      endcase
      send_idle_pct  = (phase % 4 == 1) ? 72 : (phase % 4 == 3) ? 20 : 0;
      recv_stall_pct = (phase % 4 == 2) ? 72 : (phase % 4 == 3) ? 20 : 0;
      repeat (PHASE_GROUPS) queue_random_group();
      // Hold the receiver off while the sender keeps offering, so the block backs up.
      if (phase == PRESSURE_PHASE) hold_requests++;
    end
    wait_idle();

    fail_count += expected_counts.size();
    $display("Covered %0d track groups over %0d window settings: %0d results checked,",
             groups_taken, window_setups, counts_checked);
    $display("%0d with zero pitch, %0d queries closed, %0d failures.",
             zero_pitch, queries_closed, fail_count);
    if (fail_count == 0) begin
      $display("routing_track_window_counter_top test passed");
    end else begin
      $display("routing_track_window_counter_top test failed");
    end
    $finish;
  end

endmodule
